>>> hw/rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// shared types, codes and constants of the waypoint setpoint sequencer
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned YAW_W    = 16;
  localparam int unsigned TOL_W    = 31;
  localparam int unsigned OFF_W    = POS_W + 1;
  localparam int unsigned XY_W     = POS_W + 3;
  localparam int unsigned ANG_W    = POS_W + 2;
  localparam int unsigned MAG_W    = POS_W + 1;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned LUT_W    = 30;
  localparam int unsigned LUT_IDX_W = 5;
  localparam int unsigned ENT_W    = 3 * POS_W + YAW_W;

  localparam logic [30:0]      PI_Q29    = 31'd1686629713;
  localparam logic [PROD_W-1:0] ROUND_HALF = 64'h0000_4000_0000_0000;
  localparam logic [16:0]      YAW_LIMIT = 17'd25736;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_SETPOINT = 2'd0,
    ST_QUEUED   = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic fetch;
    logic init;
    logic iter;
    logic mul;
    logic rnd;
    logic done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_cordic;
    logic step_last;
    logic out_free;
  } sts_t;

  // arctangent table in binary angle units, 2^32 per turn
  function automatic logic [LUT_W-1:0] atan_lut(input logic [LUT_IDX_W-1:0] idx);
    logic [LUT_W-1:0] v;
    case (idx)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'h0000A2FA;
      5'd15:   v = 30'h0000517D;
      5'd16:   v = 30'h000028BE;
      5'd17:   v = 30'h0000145F;
      5'd18:   v = 30'h00000A30;
      5'd19:   v = 30'h00000518;
      5'd20:   v = 30'h0000028C;
      5'd21:   v = 30'h00000146;
      5'd22:   v = 30'h000000A3;
      5'd23:   v = 30'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/wss_ctrl.sv
// ----------------------------------------------------------------------------
// wss_ctrl
// sequencing state machine: accept, queue fetch, cordic steps, multiply, rounding, result
// ----------------------------------------------------------------------------
module wss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wss_pkg::sts_t sts_i,
  output wss_pkg::cmd_t cmd_o
);
  import wss_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_INIT  = 7'b0000100,
    S_ITER  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_RND   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = sts_i.need_cordic ? S_INIT : S_DONE;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_ITER;
      end
      S_ITER: begin
        cmd_o.iter = 1'b1;
        if (sts_i.step_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_RND;
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/wss_dp.sv
// ----------------------------------------------------------------------------
// wss_dp
// waypoint queue memory, offsets, iterative cordic atan2, yaw scaling, result
// ----------------------------------------------------------------------------
module wss_dp #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [wss_pkg::TOL_W-1:0]         cfg_wr_data_i,
  input  logic                              in_kind_i,
  input  logic [wss_pkg::ENT_W-1:0]         in_data_i,
  input  wss_pkg::cmd_t                     cmd_i,
  output wss_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        out_user_o,
  output logic [wss_pkg::ENT_W-1:0]         out_data_o
);
  import wss_pkg::*;

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);

  // queue
  logic [ENT_W-1:0] mem_q [QUEUE_DEPTH];
  logic [ENT_W-1:0] rd_q;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             full, empty;

  // latched item and front waypoint
  logic                    kind_q;
  logic signed [POS_W-1:0] pos_n_q, pos_e_q, pos_d_q;
  logic [ENT_W-1:0]        in_q;
  logic signed [POS_W-1:0] wp_n_q, wp_e_q, wp_d_q;
  logic signed [YAW_W-1:0] wp_y_q;
  logic signed [OFF_W-1:0] off_n_q, off_e_q, off_d_q;

  // cordic
  logic signed [XY_W-1:0]  x_q, y_q, xs, ys;
  logic signed [ANG_W-1:0] z_q, z_abs, at;
  logic [STEP_W-1:0]       step_q;
  logic [PROD_W-1:0]       prod_q, rsum;
  logic                    zneg_q;
  logic [16:0]             rmag, rsat;
  logic signed [YAW_W-1:0] yaw_q, yaw_calc;

  logic [TOL_W-1:0]        tol_q;
  logic [MAG_W-1:0]        mag_n, mag_e, mag_d;
  logic                    adv;
  logic signed [YAW_W-1:0] rd_yaw;

  logic                    out_valid_q;
  logic [2:0]              out_user_q;
  logic [ENT_W-1:0]        out_data_q;

  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign rd_yaw = rd_q[ENT_W-1 -: YAW_W];

  assign sts_o.need_cordic = (kind_q == KIND_TICK) && !empty && (rd_yaw == '0);
  assign sts_o.step_last   = (step_q == STEP_W'(CORDIC_STEPS - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.done && (kind_q == KIND_LOAD) && !full) begin
      mem_q[tail_q] <= in_q;
    end
    rd_q <= mem_q[head_q];
  end

  // offsets and tolerance test
  always_comb begin
    mag_n = off_n_q[OFF_W-1] ? MAG_W'(-off_n_q) : MAG_W'(off_n_q);
    mag_e = off_e_q[OFF_W-1] ? MAG_W'(-off_e_q) : MAG_W'(off_e_q);
    mag_d = off_d_q[OFF_W-1] ? MAG_W'(-off_d_q) : MAG_W'(off_d_q);
    adv   = (count_q > CNT_W'(1)) &&
            (mag_n < MAG_W'(tol_q)) && (mag_e < MAG_W'(tol_q)) && (mag_d < MAG_W'(tol_q));
  end

  // cordic step and yaw scaling
  always_comb begin
    xs       = x_q >>> step_q;
    ys       = y_q >>> step_q;
    at       = $signed(ANG_W'(atan_lut(LUT_IDX_W'(step_q))));
    z_abs    = z_q[ANG_W-1] ? -z_q : z_q;
    rsum     = prod_q + ROUND_HALF;
    rmag     = rsum[PROD_W-1 -: 17];
    rsat     = (rmag > YAW_LIMIT) ? YAW_LIMIT : rmag;
    yaw_calc = zneg_q ? -$signed(YAW_W'(rsat)) : $signed(YAW_W'(rsat));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q  <= in_kind_i;
      in_q    <= in_data_i;
      pos_n_q <= in_data_i[POS_W-1:0];
      pos_e_q <= in_data_i[2*POS_W-1:POS_W];
      pos_d_q <= in_data_i[3*POS_W-1:2*POS_W];
    end
    if (cmd_i.fetch) begin
      wp_n_q  <= rd_q[POS_W-1:0];
      wp_e_q  <= rd_q[2*POS_W-1:POS_W];
      wp_d_q  <= rd_q[3*POS_W-1:2*POS_W];
      wp_y_q  <= rd_yaw;
      off_n_q <= OFF_W'($signed(rd_q[POS_W-1:0])) - OFF_W'(pos_n_q);
      off_e_q <= OFF_W'($signed(rd_q[2*POS_W-1:POS_W])) - OFF_W'(pos_e_q);
      off_d_q <= OFF_W'($signed(rd_q[3*POS_W-1:2*POS_W])) - OFF_W'(pos_d_q);
    end
    if (cmd_i.init) begin
      step_q <= '0;
      if (off_n_q[OFF_W-1]) begin
        x_q <= -XY_W'(off_n_q);
        y_q <= -XY_W'(off_e_q);
        z_q <= off_e_q[OFF_W-1] ? -ANG_W'(34'sh0_8000_0000) : ANG_W'(34'sh0_8000_0000);
      end else begin
        x_q <= XY_W'(off_n_q);
        y_q <= XY_W'(off_e_q);
        z_q <= '0;
      end
    end
    if (cmd_i.iter) begin
      step_q <= step_q + 1'b1;
      if (!y_q[XY_W-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
    if (cmd_i.mul) begin
      zneg_q <= z_q[ANG_W-1];
      prod_q <= PROD_W'(z_abs[MAG_W-1:0]) * PROD_W'(PI_Q29);
    end
    if (cmd_i.rnd) begin
      yaw_q <= (off_n_q == '0 && off_e_q == '0) ? '0 : yaw_calc;
    end
  end

  // queue pointers and result
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.done) begin
      if (kind_q == KIND_LOAD) begin
        if (!full) begin
          tail_d  = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          count_d = count_q + 1'b1;
        end
      end else if (!empty && adv) begin
        head_d  = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      tol_q       <= TOL_W'(65536);
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (cfg_wr_en_i) begin
        tol_q <= cfg_wr_data_i;
      end
      if (cmd_i.done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      out_data_q <= '0;
      if (kind_q == KIND_LOAD) begin
        out_user_q <= {1'b0, full ? ST_DROPPED : ST_QUEUED};
      end else if (empty) begin
        out_user_q <= {1'b0, ST_EMPTY};
      end else begin
        out_user_q <= {adv, ST_SETPOINT};
        out_data_q <= {(wp_y_q != '0) ? wp_y_q : yaw_q, wp_d_q, wp_e_q, wp_n_q};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_user_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hw/rtl/waypoint_setpoint_sequencer_unit.sv
// ----------------------------------------------------------------------------
// waypoint_setpoint_sequencer_unit
// waypoint queue with setpoint generation and cordic atan2 yaw
// ----------------------------------------------------------------------------
// one item is worked on at a time. a load, a tick on an empty queue and a tick
// whose front waypoint has a stored yaw go through queue read and result only;
// a tick that computes the yaw also goes through the iterative cordic unit, one
// rotation a cycle, then the scaling multiply and rounding. the offsets come with
// the queue read. the result sits in an output register, so a stalled result
// delays only the following item's end.
// ----------------------------------------------------------------------------
module waypoint_setpoint_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [wss_pkg::TOL_W-1:0] cfg_wr_data_i,   // reach_tolerance
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [111:0]              s_axis_tdata,    // north, east, down, heading
  input  logic                      s_axis_tuser,    // kind
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [111:0]              m_axis_tdata,    // target_north/east/down/yaw
  output logic [2:0]                m_axis_tuser     // status, advanced
);
  import wss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wss_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_kind_i     (s_axis_tuser),
    .in_data_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_user_o    (m_axis_tuser),
    .out_data_o    (m_axis_tdata)
  );

endmodule

>>> sim/setpoint_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setpoint_checker
// watches both item channels and the tolerance port of the waypoint setpoint
// sequencer, predicts the result of each accepted item from its own copy of
// the waypoint queue and compares every returned result field by field
// ----------------------------------------------------------------------------
module setpoint_checker #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_wr_en_i,
  input  logic [30:0]  cfg_wr_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,    // north, east, down, heading
  input  logic         s_axis_tuser,    // kind
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,    // target_north/east/down/yaw
  input  logic [2:0]   m_axis_tuser,    // status, advanced
  output int           errors_o,
  output int           pending_o
);
  import wss_pkg::*;

  typedef struct packed {
    status_e     status;
    logic        advanced;
    logic [15:0] yaw;
    logic [31:0] down;
    logic [31:0] east;
    logic [31:0] north;
  } setpoint_t;

  logic signed [31:0] wp_north [DEPTH];
  logic signed [31:0] wp_east  [DEPTH];
  logic signed [31:0] wp_down  [DEPTH];
  logic [15:0]        wp_yaw   [DEPTH];
  int unsigned        wp_head;
  int unsigned        wp_count;
  logic [30:0]        reach_tol;
  setpoint_t          setpoint_q [$];
  int                 mismatches = 0;
  int                 result_idx = 0;

  assign errors_o = mismatches;

  // binary angle units, one turn is 2^32
  function automatic longint turn_angle(int i);
    case (i)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      15: return 64'h0000517D;
      16: return 64'h000028BE;
      17: return 64'h0000145F;
      18: return 64'h00000A30;
      19: return 64'h00000518;
      20: return 64'h0000028C;
      21: return 64'h00000146;
      22: return 64'h000000A3;
      23: return 64'h00000051;
      default: return 64'h0;
    endcase
  endfunction

  function automatic logic [15:0] bearing_yaw(longint dn, longint de);
    longint x, y, z, xs, ys, q;
    longint unsigned a, r;
    if (dn == 0 && de == 0) return 16'd0;
    x = dn;
    y = de;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + turn_angle(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - turn_angle(i);
      end
    end
    a = (z < 0) ? -z : z;
    // scale by pi * 2^29 / 2^47, round half away from zero
    r = (a * 64'd1686629713 + (64'd1 << 46)) >> 47;
    if (r > 64'd25736) r = 64'd25736;
    q = r;
    return (z < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic longint abs_gap(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic predict_item(input kind_e kind, input logic [111:0] data,
                              output setpoint_t sp);
    logic signed [31:0] n, e, d;
    int unsigned        slot;
    longint             dn, de, dd, tol;
    n  = data[31:0];
    e  = data[63:32];
    d  = data[95:64];
    sp = '0;
    sp.status = ST_SETPOINT;
    if (kind == KIND_LOAD) begin
      if (wp_count < DEPTH) begin
        slot = (wp_head + wp_count) % DEPTH;
        wp_north[slot] = n;
        wp_east[slot]  = e;
        wp_down[slot]  = d;
        wp_yaw[slot]   = data[111:96];
        wp_count++;
        sp.status = ST_QUEUED;
      end else begin
        sp.status = ST_DROPPED;
      end
    end else if (wp_count == 0) begin
      sp.status = ST_EMPTY;
    end else begin
      dn  = longint'(wp_north[wp_head]) - longint'(n);
      de  = longint'(wp_east[wp_head]) - longint'(e);
      dd  = longint'(wp_down[wp_head]) - longint'(d);
      tol = longint'(reach_tol);
      sp.north = wp_north[wp_head];
      sp.east  = wp_east[wp_head];
      sp.down  = wp_down[wp_head];
      sp.yaw   = (wp_yaw[wp_head] != 16'd0) ? wp_yaw[wp_head] : bearing_yaw(dn, de);
      // last waypoint stays in the queue
      if (wp_count > 1 && abs_gap(dn) < tol && abs_gap(de) < tol && abs_gap(dd) < tol) begin
        wp_head = (wp_head + 1) % DEPTH;
        wp_count--;
        sp.advanced = 1'b1;
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("result %0d: %0s is %h, expected %h (t=%0t)", result_idx, what, got, want,
             $realtime);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    setpoint_t got, want;
    if (!rst_ni) begin
      wp_head   = 0;
      wp_count  = 0;
      reach_tol = 31'd65536;
      setpoint_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_wr_en_i) reach_tol = cfg_wr_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.north    = m_axis_tdata[31:0];
        got.east     = m_axis_tdata[63:32];
        got.down     = m_axis_tdata[95:64];
        got.yaw      = m_axis_tdata[111:96];
        got.status   = status_e'(m_axis_tuser[1:0]);
        got.advanced = m_axis_tuser[2];
        if (setpoint_q.size() == 0) begin
          flag_mismatch("unexpected result, status", 32'(m_axis_tuser), 32'h0);
        end else begin
          want = setpoint_q.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.north !== want.north) flag_mismatch("target_north", got.north, want.north);
          if (got.east !== want.east) flag_mismatch("target_east", got.east, want.east);
          if (got.down !== want.down) flag_mismatch("target_down", got.down, want.down);
          if (got.yaw !== want.yaw) flag_mismatch("target_yaw", 32'(got.yaw), 32'(want.yaw));
          if (got.advanced !== want.advanced)
            flag_mismatch("advanced", 32'(got.advanced), 32'(want.advanced));
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(kind_e'(s_axis_tuser), s_axis_tdata, want);
        setpoint_q.push_back(want);
      end
      pending_o <= setpoint_q.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives load and tick items into the waypoint setpoint sequencer: a directed
// opening that fills, overflows and walks the queue, then random routes under
// several reach tolerances, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_top;
  import wss_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          PHASE_ITEMS = 235;
  localparam int          LIMIT       = 500000;
  localparam int          QUIET       = 30;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_wr_en_i   = 1'b0;
  logic [30:0]  cfg_wr_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  int           errors;
  int           pending;
  int           cycles        = 0;
  logic         calm          = 1'b0;

  // route as the sender sees it, used to aim ticks at the front waypoint
  logic signed [31:0] route_n [DEPTH];
  logic signed [31:0] route_e [DEPTH];
  logic signed [31:0] route_d [DEPTH];
  int unsigned        route_head  = 0;
  int unsigned        route_count = 0;
  longint             route_tol   = 65536;

  waypoint_setpoint_sequencer_unit #(
    .QUEUE_DEPTH  (DEPTH),
    .CORDIC_STEPS (16)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  setpoint_checker #(
    .DEPTH (DEPTH),
    .STEPS (16)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(0, 99) >= 29);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint gap(logic signed [31:0] a, logic [31:0] b);
    longint diff;
    diff = longint'(a) - longint'(signed'(b));
    return (diff < 0) ? -diff : diff;
  endfunction

  function automatic void track_route(kind_e kind, logic [31:0] n, e, d);
    int unsigned slot;
    if (kind == KIND_LOAD) begin
      if (route_count < DEPTH) begin
        slot = (route_head + route_count) % DEPTH;
        route_n[slot] = n;
        route_e[slot] = e;
        route_d[slot] = d;
        route_count++;
      end
    end else if (route_count > 1 && gap(route_n[route_head], n) < route_tol &&
                 gap(route_e[route_head], e) < route_tol &&
                 gap(route_d[route_head], d) < route_tol) begin
      route_head = (route_head + 1) % DEPTH;
      route_count--;
    end
  endfunction

  // 0 exact, 1 inside the tolerance, 2 on the tolerance, else anywhere
  function automatic logic [31:0] aim_at(logic signed [31:0] c, int unsigned how);
    longint j;
    case (how)
      0: j = 0;
      1: j = (route_tol > 1) ?
             longint'($urandom_range(0, 32'(2 * route_tol - 2))) - (route_tol - 1) : 0;
      2: j = ($urandom_range(0, 1) != 0) ? route_tol : -route_tol;
      default: j = longint'($urandom);
    endcase
    return 32'(longint'(c) + j);
  endfunction

  function automatic logic [31:0] any_coord();
    if ($urandom_range(0, 1) != 0) return $urandom;
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic logic [15:0] any_heading();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 16'd0;
    if (pick < 85) return 16'($urandom_range(0, 51472)) - 16'd25736;
    return 16'($urandom);
  endfunction

  task automatic send_item(input kind_e kind, input logic [31:0] n, e, d,
                           input logic [15:0] h);
    if (!calm && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h, d, e, n};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    track_route(kind, n, e, d);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (QUIET) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [30:0] v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    route_tol = v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick, how, odd, base, rim;
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      send_item(KIND_LOAD, any_coord(), any_coord(), any_coord(), any_heading());
    end else if (route_count > 0 && pick < 90) begin
      how  = $urandom_range(0, 9);
      base = (how == 5) ? 0 : 1;
      odd  = (how >= 6) ? $urandom_range(0, 2) : 3;
      rim  = (how < 8) ? 2 : 3;
      send_item(KIND_TICK, aim_at(route_n[route_head], (odd == 0) ? rim : base),
                aim_at(route_e[route_head], (odd == 1) ? rim : base),
                aim_at(route_d[route_head], (odd == 2) ? rim : base), 16'($urandom));
    end else begin
      send_item(KIND_TICK, $urandom, $urandom, $urandom, 16'($urandom));
    end
  endtask

  initial begin
    logic [30:0] tol_val;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, then fill past full
    send_item(KIND_TICK, $urandom, $urandom, $urandom, 16'($urandom));
    send_item(KIND_LOAD, 32'h0, 32'h0, 32'h0, 16'h0);
    send_item(KIND_LOAD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h0);
    send_item(KIND_LOAD, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'sd25736);
    send_item(KIND_LOAD, 32'hFFFB0000, 32'h00030000, 32'h0, -16'sd25736);
    send_item(KIND_LOAD, 32'h12345678, 32'hFEDCBA98, 32'h0F0F0F0F, 16'h8000);
    send_item(KIND_LOAD, 32'hEDCBA987, 32'h01234567, 32'hF0F0F0F0, 16'h7FFF);
    for (int i = 0; i < 11; i++)
      send_item(KIND_LOAD, any_coord(), any_coord(), any_coord(), any_heading());

    // walk the front: zero offsets, widest offsets, inside and on the tolerance
    send_item(KIND_TICK, 32'h0, 32'h0, 32'h0, 16'hFFFF);
    send_item(KIND_TICK, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h0);
    send_item(KIND_TICK, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h0);
    send_item(KIND_TICK, 32'h8000FFFF, 32'h7FFF0001, 32'h8000FFFF, 16'h0);
    send_item(KIND_TICK, 32'hFFFA0000, 32'h00030000, 32'h0, 16'h0);
    send_item(KIND_TICK, 32'hFFFB0000, 32'h00030000, 32'h0, 16'h0);
    send_item(KIND_TICK, 32'h12345678, 32'hFEDCBA98, 32'h0F0F0F0F, 16'h0);
    send_item(KIND_TICK, $urandom, $urandom, $urandom, 16'($urandom));

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0:       tol_val = 31'd65536;
        1:       tol_val = 31'd0;
        2:       tol_val = 31'h7FFFFFFF;
        3:       tol_val = 31'($urandom_range(1, 32'h0010_0000));
        4:       tol_val = 31'd1;
        default: tol_val = 31'($urandom);
      endcase
      write_tolerance(tol_val);
      calm <= (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
